/* rtl/core/pott_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pott_pkg;

  // input item modes
  localparam logic [1:0] MODE_TICK         = 2'd0;
  localparam logic [1:0] MODE_ADD_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_ADD_ONESHOT  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } pott_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_start;
    logic step;
    logic add;
    logic emit_done;
  } pott_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic fire;
    logic last_entry;
    logic empty;
  } pott_stat_t;

endpackage

`default_nettype wire

/* rtl/core/pott_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pott_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  timer_id;
  logic [31:0] tick_count;

  modport source (output valid, output mode, output timer_id, output tick_count,
                  input ready);
  modport sink (input valid, input mode, input timer_id, input tick_count,
                output ready);
endinterface

interface pott_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] fired_id;
  logic       last;

  modport source (output valid, output kind, output fired_id, output last,
                  input ready);
  modport sink (input valid, input kind, input fired_id, input last,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/pott_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

`default_nettype wire

/* rtl/core/pott_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pott_ctrl
  import pott_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire logic [1:0] item_mode,
  output logic            item_ready,
  input  wire pott_stat_t stat,
  output pott_cmd_t       cmd
);
  pott_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        item_ready = !rst;
        if (item_valid && !rst) begin
          cmd.capture = 1'b1;
          case (item_mode) inside
            MODE_TICK:                           state_next = stat.empty ? ST_DONE : ST_READ;
            MODE_ADD_PERIODIC, MODE_ADD_ONESHOT: state_next = ST_ADD;
            default:                             state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (stat.out_free) begin
          cmd.add    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_start = 1'b1;
        state_next   = ST_EVAL;
      end
      ST_EVAL: begin
        // a firing entry waits for the output register
        if (!stat.fire || stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.last_entry) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.rd_start, cmd.step, cmd.add, cmd.emit_done}))
    else $error("controller issued overlapping commands");

  a_walk_reads_first: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> ($past(cmd.rd_start) || $past(cmd.step) || !$past(stat.out_free)))
    else $error("entry evaluated without a preceding read");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (state == ST_IDLE))
    else $error("input offered ready outside idle");
`endif
endmodule

`default_nettype wire

/* rtl/core/pott_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module pott_dp
  import pott_pkg::*;
#(
  parameter int MAX_ENTRIES = 8,
  parameter int ID_BITS     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pott_cmd_t   cmd,
  output pott_stat_t       stat,
  input  wire logic [1:0]  item_mode,
  input  wire logic [7:0]  item_timer_id,
  input  wire logic [31:0] item_tick_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_fired_id,
  output logic             out_last
);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = ID_BITS + 64;

  logic [CW-1:0]      occ, rd_idx, wr_idx, rd_next;
  logic               cap_periodic;
  logic [ID_BITS-1:0] cap_id;
  logic [31:0]        cap_cnt;

  logic               ram_wr_en, ram_rd_en;
  logic [IW-1:0]      ram_wr_addr, ram_rd_addr;
  logic [EW-1:0]      ram_wr_data, ram_rd_data;

  logic [ID_BITS-1:0] e_id;
  logic [31:0]        e_reload, e_rem, per_val, add_reload, add_rem;
  logic               fire, keep, full, last_entry, out_free, emit;

  assign e_id     = ram_rd_data[EW-1 -: ID_BITS];
  assign e_reload = ram_rd_data[63:32];
  assign e_rem    = ram_rd_data[31:0];

  // zero and one both fire; periodic zero acts as one
  assign fire       = (e_rem[31:1] == 31'd0);
  assign keep       = !fire || (e_reload != 32'd0);
  assign rd_next    = rd_idx + 1'b1;
  assign last_entry = (rd_next == occ);
  assign full       = (occ == CW'(MAX_ENTRIES));
  assign out_free   = !out_valid || out_ready;
  assign emit       = cmd.add || cmd.emit_done || (cmd.step && fire);

  assign per_val    = (cap_cnt == 32'd0) ? 32'd1 : cap_cnt;
  assign add_reload = cap_periodic ? per_val : 32'd0;
  assign add_rem    = cap_periodic ? per_val : cap_cnt;

  assign stat.out_free   = out_free;
  assign stat.fire       = fire;
  assign stat.last_entry = last_entry;
  assign stat.empty      = (occ == '0);

  // surviving entries are written back compacted at wr_idx
  always_comb begin
    ram_wr_en   = (cmd.step && keep) || (cmd.add && !full);
    ram_wr_addr = cmd.add ? occ[IW-1:0] : wr_idx[IW-1:0];
    if (cmd.add) begin
      ram_wr_data = {cap_id, add_reload, add_rem};
    end else begin
      ram_wr_data = {e_id, e_reload, fire ? e_reload : (e_rem - 32'd1)};
    end
    ram_rd_en   = cmd.rd_start || (cmd.step && !last_entry);
    ram_rd_addr = cmd.step ? rd_next[IW-1:0] : rd_idx[IW-1:0];
  end

  pott_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_idx <= '0;
      wr_idx <= '0;
    end else begin
      if (cmd.capture) begin
        rd_idx <= '0;
        wr_idx <= '0;
      end
      if (cmd.step) begin
        rd_idx <= rd_next;
        if (keep) begin
          wr_idx <= wr_idx + 1'b1;
        end
      end
      if (cmd.add && !full) begin
        occ <= occ + 1'b1;
      end
      if (cmd.emit_done) begin
        occ <= wr_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_periodic <= (item_mode == MODE_ADD_PERIODIC);
      cap_id       <= ID_BITS'(item_timer_id);
      cap_cnt      <= item_tick_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      out_kind     <= full ? KIND_REJECT : KIND_ACCEPT;
      out_fired_id <= 8'(cap_id);
      out_last     <= 1'b1;
    end else if (cmd.emit_done) begin
      out_kind     <= KIND_DONE;
      out_fired_id <= 8'd0;
      out_last     <= 1'b1;
    end else if (cmd.step && fire) begin
      out_kind     <= KIND_FIRED;
      out_fired_id <= 8'(e_id);
      out_last     <= 1'b0;
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(MAX_ENTRIES))
    else $error("occupancy beyond table size");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    wr_idx <= rd_idx)
    else $error("write pointer passed read pointer");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote a pending result");

  a_occ_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (occ != $past(occ))) |-> $past(cmd.add || cmd.emit_done))
    else $error("occupancy changed outside add or tick end");
`endif
endmodule

`default_nettype wire

/* rtl/core/periodic_oneshot_timer_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// table of up to MAX_ENTRIES software timers, kept compact in insertion order
// item channel: mode 0 tick, 1 add periodic timer, 2 add one-shot timer;
//   mode 3 is dropped with no result
// result channel: kind, fired_id and last; every item's final result has last set
// an add gives one transaction: accepted, or rejected when full
// a tick walks the stored entries through one single-port-read ram, one entry a
//   cycle unless a firing entry waits for the output register, in the steps
//   accept, first read, walk, done; it gives one fired transaction per expiring
//   entry, then a done transaction; a tick on an empty table skips the read and walk
// the first result is registered in the add or done state for an add or a tick
//   on an empty table, and in the walk or done state for a tick that walks entries
// fired one-shot entries are dropped and later ones moved down during the same walk
// results go through a single output register: a stalled receiver holds the walk
//   on the entry that is about to fire; a new item is taken once the last
//   result sits in the output register
// reset (synchronous, active high) empties the table; ram contents are not cleared
module periodic_oneshot_timer_table
  import pott_pkg::*;
#(
  parameter int MAX_ENTRIES = 8,
  parameter int ID_BITS     = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  pott_in_if.sink   item,
  pott_out_if.source result
);
  pott_cmd_t  cmd;
  pott_stat_t stat;

  // sequencer: idle, add, first read, walk, done
  pott_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.mode),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // entry ram, walk pointers, occupancy and output register
  pott_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .item_mode       (item.mode),
    .item_timer_id   (item.timer_id),
    .item_tick_count (item.tick_count),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_kind        (result.kind),
    .out_fired_id    (result.fired_id),
    .out_last        (result.last)
  );
endmodule

`default_nettype wire

/* tb/sv/periodic_oneshot_timer_table_test.sv */
`timescale 1ns / 1ps

module periodic_oneshot_timer_table_test;
  import pott_pkg::*;

  localparam int NUM_TIMERS      = 8;
  localparam int TIMER_ID_BITS   = 8;
  localparam int RANDOM_ITEMS    = 225;
  localparam int IDLE_PCT        = 35;
  localparam int TIMEOUT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES   = 20;
  // receiver hold-off that backs the table up into its input
  localparam int STALL_AT_RESULT = 80;
  localparam int STALL_CYCLES    = 400;
  // receiver window with ready held high
  localparam int EAGER_FIRST     = 250;
  localparam int EAGER_LAST      = 400;
  // mode with no meaning, dropped by the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one input transaction plus pacing hints for the driver
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  timer_id;
    logic [31:0] tick_count;
    bit          drain;   // hold this item back until all results are in
    bit          no_gap;  // offer this item without random idling
  } timer_cmd_t;

  // one result transaction
  typedef struct {
    logic [1:0] kind;
    logic [7:0] fired_id;
    logic       last;
  } timer_event_t;

  logic clk;
  logic rst;

  pott_in_if  item_bus ();
  pott_out_if result_bus ();

  periodic_oneshot_timer_table #(
    .MAX_ENTRIES(NUM_TIMERS),
    .ID_BITS    (TIMER_ID_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(result_bus)
  );

  // commands waiting to be offered, and the one on the bus right now
  timer_cmd_t   pending_cmds[$];
  timer_cmd_t   offered_cmd;
  // results the table still owes us, oldest first
  timer_event_t expected_events[$];

  // shadow copy of the timer table
  logic [7:0]   shadow_id[NUM_TIMERS];
  logic [31:0]  shadow_reload[NUM_TIMERS];
  logic [31:0]  shadow_left[NUM_TIMERS];
  int unsigned  shadow_count;

  int unsigned  total_cmds;
  int unsigned  accepted_cmds;
  int unsigned  seen_events;
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  stall_left;
  bit           stall_done;

  // coverage tallies for the summary
  int unsigned  n_ticks;
  int unsigned  n_adds;
  int unsigned  n_rejects;
  int unsigned  n_fires;
  int unsigned  n_dropped;
  int unsigned  max_fires_per_tick;

  // free-running clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard limit on run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_events.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // work out the results of one accepted command and update the shadow table
  function automatic void predict_timer_events(timer_cmd_t cmd);
    int unsigned i;
    int unsigned j;
    int unsigned fires;
    logic [31:0] period;
    i = 0;
    fires = 0;
    case (cmd.mode)
      MODE_ADD_PERIODIC, MODE_ADD_ONESHOT: begin
        if (shadow_count >= NUM_TIMERS) begin
          // table full: reject, state unchanged
          expected_events.push_back('{kind: KIND_REJECT, fired_id: cmd.timer_id, last: 1'b1});
          n_rejects++;
        end else begin
          shadow_id[shadow_count] = cmd.timer_id;
          if (cmd.mode == MODE_ADD_PERIODIC) begin
            // a zero period is treated as a period of one
            period = (cmd.tick_count == 32'd0) ? 32'd1 : cmd.tick_count;
            shadow_reload[shadow_count] = period;
            shadow_left[shadow_count]   = period;
          end else begin
            // one-shot: reload zero marks it for removal once it fires
            shadow_reload[shadow_count] = 32'd0;
            shadow_left[shadow_count]   = cmd.tick_count;
          end
          shadow_count++;
          expected_events.push_back('{kind: KIND_ACCEPT, fired_id: cmd.timer_id, last: 1'b1});
          n_adds++;
        end
      end
      MODE_TICK: begin
        // walk the table in order; a count of zero or one fires on this tick
        while (i < shadow_count) begin
          if (shadow_left[i] > 32'd1) begin
            shadow_left[i] = shadow_left[i] - 32'd1;
            i++;
          end else begin
            expected_events.push_back('{kind: KIND_FIRED, fired_id: shadow_id[i], last: 1'b0});
            fires++;
            if (shadow_reload[i] != 32'd0) begin
              shadow_left[i] = shadow_reload[i];
              i++;
            end else begin
              // one-shot leaves; later entries move down, same slot is looked at again
              for (j = i + 1; j < shadow_count; j++) begin
                shadow_id[j-1]     = shadow_id[j];
                shadow_reload[j-1] = shadow_reload[j];
                shadow_left[j-1]   = shadow_left[j];
              end
              shadow_count--;
            end
          end
        end
        expected_events.push_back('{kind: KIND_DONE, fired_id: 8'd0, last: 1'b1});
        n_ticks++;
        n_fires += fires;
        if (fires > max_fires_per_tick) max_fires_per_tick = fires;
      end
      default: begin
        // unused mode gives nothing
        n_dropped++;
      end
    endcase
  endfunction

  function automatic timer_cmd_t make_cmd(logic [1:0] mode, logic [7:0] id, logic [31:0] cnt);
    timer_cmd_t cmd;
    cmd.mode       = mode;
    cmd.timer_id   = id;
    cmd.tick_count = cnt;
    cmd.drain      = 1'b0;
    cmd.no_gap     = 1'b0;
    return cmd;
  endfunction

  // driver: offers queued commands, keeps each on the bus until it is taken
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = item_bus.valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        predict_timer_events(offered_cmd);
        accepted_cmds++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_cmds.size() != 0) begin
        // a drain item waits until every owed result has come back
        if (!(pending_cmds[0].drain && expected_events.size() != 0) &&
            (pending_cmds[0].no_gap || $urandom_range(99) >= IDLE_PCT)) begin
          offered_cmd = pending_cmds.pop_front();
          nxt_valid   = 1'b1;
          item_bus.mode       <= offered_cmd.mode;
          item_bus.timer_id   <= offered_cmd.timer_id;
          item_bus.tick_count <= offered_cmd.tick_count;
        end
      end
    end
    item_bus.valid <= nxt_valid;
  end

  // monitor: checks each result transaction against the oldest owed one
  always @(posedge clk) begin
    timer_event_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        seen_events++;
        if (expected_events.size() == 0) begin
          $error("result with nothing owed: kind %0d fired_id %0d last %0d",
                 result_bus.kind, result_bus.fired_id, result_bus.last);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          if (result_bus.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, result_bus.kind);
            error_count++;
          end
          if (result_bus.fired_id !== want.fired_id) begin
            $error("fired_id: expected %0d, actual %0d", want.fired_id, result_bus.fired_id);
            error_count++;
          end
          if (result_bus.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, result_bus.last);
            error_count++;
          end
        end
      end
      // pace ready: one long hold-off, one eager window, random idling otherwise
      if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (!stall_done && seen_events >= STALL_AT_RESULT) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES - 1;
        result_bus.ready <= 1'b0;
      end else if (seen_events >= EAGER_FIRST && seen_events < EAGER_LAST) begin
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    timer_cmd_t  cmd;
    int unsigned counted;
    int unsigned periodic_left;
    int unsigned roll;
    logic [31:0] delay;

    // known values on every input from time zero
    rst                 = 1'b1;
    item_bus.valid      = 1'b0;
    item_bus.mode       = MODE_TICK;
    item_bus.timer_id   = 8'd0;
    item_bus.tick_count = 32'd0;
    result_bus.ready    = 1'b0;
    cycle_count   = 0;
    accepted_cmds = 0;
    seen_events   = 0;
    error_count   = 0;
    stall_left    = 0;
    stall_done    = 1'b0;
    shadow_count  = 0;
    n_ticks = 0;
    n_adds = 0;
    n_rejects = 0;
    n_fires = 0;
    n_dropped = 0;
    max_fires_per_tick = 0;

    // directed part
    // tick on an empty table, with every field bit set
    pending_cmds.push_back(make_cmd(MODE_TICK, 8'hFF, 32'hFFFF_FFFF));
    // periodic with zero period runs as period one
    pending_cmds.push_back(make_cmd(MODE_ADD_PERIODIC, 8'h00, 32'd0));
    // one-shot with zero delay fires next tick, no wrap
    pending_cmds.push_back(make_cmd(MODE_ADD_ONESHOT, 8'hFF, 32'd0));
    // one-shot with delay one also fires next tick
    pending_cmds.push_back(make_cmd(MODE_ADD_ONESHOT, 8'h5A, 32'd1));
    // widest period, never fires within the run
    pending_cmds.push_back(make_cmd(MODE_ADD_PERIODIC, 8'hA5, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(MODE_ADD_ONESHOT, 8'h11, 32'd3));
    // removal of two adjacent one-shots in the same walk
    pending_cmds.push_back(make_cmd(MODE_TICK, 8'h00, 32'd0));
    // unused mode is dropped
    pending_cmds.push_back(make_cmd(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF));
    // fill the table
    for (int k = 0; k < 5; k++) begin
      pending_cmds.push_back(make_cmd(MODE_ADD_ONESHOT, 8'(8'h21 + k), 32'd2));
    end
    // table full: both add flavors rejected
    pending_cmds.push_back(make_cmd(MODE_ADD_ONESHOT, 8'hC3, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(MODE_ADD_PERIODIC, 8'h3C, 32'd7));
    pending_cmds.push_back(make_cmd(MODE_TICK, 8'h00, 32'd0));
    // most of the table expires at once, with shifting down
    pending_cmds.push_back(make_cmd(MODE_TICK, 8'h00, 32'd0));
    // refill with short one-shots and let them all go in one tick
    for (int k = 0; k < 6; k++) begin
      pending_cmds.push_back(make_cmd(MODE_ADD_ONESHOT, 8'(8'h80 + k), 32'd1));
    end
    pending_cmds.push_back(make_cmd(MODE_TICK, 8'h00, 32'd0));

    // random part: mostly adds of short timers mixed with ticks, a little noise
    counted = 0;
    periodic_left = 2;   // periodic timers never leave, so only a few of them
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        // noise: unused mode, not counted
        cmd = make_cmd(MODE_UNUSED, 8'($urandom), $urandom);
      end else begin
        if (roll < 50) begin
          // tick fields are ignored, so they carry random bits
          cmd = make_cmd(MODE_TICK, 8'($urandom), $urandom);
        end else if (roll < 54 && periodic_left != 0) begin
          periodic_left--;
          cmd = make_cmd(MODE_ADD_PERIODIC, 8'($urandom), $urandom_range(6, 0));
        end else begin
          delay = ($urandom_range(19) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 0);
          cmd = make_cmd(MODE_ADD_ONESHOT, 8'($urandom), delay);
        end
        cmd.no_gap = (counted >= 60 && counted < 110);
        cmd.drain  = (counted == 120 || counted == 220);
        counted++;
      end
      pending_cmds.push_back(cmd);
    end
    total_cmds = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every command to be taken and every result to come back
    while (accepted_cmds != total_cmds || expected_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("ran %0d commands: %0d ticks, %0d adds, %0d rejects, %0d dropped",
             total_cmds, n_ticks, n_adds, n_rejects, n_dropped);
    $display("checked %0d results, %0d timer fires, up to %0d in one tick",
             seen_events, n_fires, max_fires_per_tick);
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* periodic_oneshot_timer_table.f */
rtl/core/pott_pkg.sv
rtl/core/pott_if.sv
rtl/core/pott_ram.sv
rtl/core/pott_ctrl.sv
rtl/core/pott_dp.sv
rtl/core/periodic_oneshot_timer_table.sv
tb/sv/periodic_oneshot_timer_table_test.sv
